### hdl/modexp_pkg.sv
// shared types and constants for the modular exponentiation core
`timescale 1ns / 1ps
`default_nettype none

package modexp_pkg;

	// field widths
	localparam int MOD_W  = 31;
	localparam int WORD_W = 32;

	// multiply-reduce unit: one multiplier bit per step, msb first
	localparam int STEP_CNT_W = $clog2(WORD_W) + 1;
	localparam logic [STEP_CNT_W-1:0] MUL_STEPS = STEP_CNT_W'(WORD_W);

	// modulus register after reset, smallest modulus with nonzero residues
	localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(7681);
	localparam logic [MOD_W-1:0] MOD_MIN   = MOD_W'(2);
	localparam logic [MOD_W-1:0] ONE_VAL   = MOD_W'(1);

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_NORM = 5'b00010,
		ST_LOOP = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_SQR  = 5'b10000
	} modexp_state_t;

	// request into the multiply-reduce unit: mcand * mplier mod modulus
	typedef struct packed {
		logic              start;
		logic [MOD_W-1:0]  mcand;
		logic [WORD_W-1:0] mplier;
	} mm_req_t;

	// response from the multiply-reduce unit
	typedef struct packed {
		logic             done;
		logic [MOD_W-1:0] prod;
	} mm_rsp_t;

endpackage

`default_nettype wire

### hdl/modexp_mulred.sv
// shared interleaved modular multiply-reduce unit, one multiplier bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module modexp_mulred import modexp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [MOD_W-1:0] modulus,
	input  wire mm_req_t          req,
	output mm_rsp_t               rsp
);

	logic                  run_q;
	logic                  done_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic [MOD_W-1:0]      mcand_q;
	logic [WORD_W-1:0]     mplier_q;
	logic [MOD_W-1:0]      r_q;

	logic [MOD_W+1:0]      t;
	logic [MOD_W+2:0]      d1;
	logic [MOD_W+2:0]      d2;
	logic [MOD_W-1:0]      r_next;

	// r = 2r + bit*mcand, then bring below modulus (t < 3*modulus)
	always_comb begin
		t  = {1'b0, r_q, 1'b0} + {2'b00, (mplier_q[WORD_W-1] ? mcand_q : '0)};
		d1 = {1'b0, t} - {3'b000, modulus};
		d2 = {1'b0, t} - {2'b00, modulus, 1'b0};
		if (!d2[MOD_W+2]) begin
			r_next = d2[MOD_W-1:0];
		end else if (!d1[MOD_W+2]) begin
			r_next = d1[MOD_W-1:0];
		end else begin
			r_next = t[MOD_W-1:0];
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= MUL_STEPS;
		end else if (run_q) begin
			cnt_q <= cnt_q - STEP_CNT_W'(1);
			if (cnt_q == STEP_CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// operand and remainder registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			mcand_q  <= req.mcand;
			mplier_q <= req.mplier;
			r_q      <= '0;
		end else if (run_q) begin
			mplier_q <= {mplier_q[WORD_W-2:0], 1'b0};
			r_q      <= r_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = r_q;

	// partial remainder stays reduced while stepping
	a_rem_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> (r_q < modulus))
		else $error("partial remainder not below modulus");

	// completion follows the last step only
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(run_q) && !run_q))
		else $error("done without a finished run");

	// the step counter is never zero while running
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> (cnt_q != '0))
		else $error("step counter ran out while running");

endmodule

`default_nettype wire

### hdl/modular_exponentiation_core.sv
// modular exponentiation core: right-to-left square-and-multiply over a shared reducer
//
// channel   ports                                 transfer
// --------  ------------------------------------  -------------------------------
// command   start, busy, base, exponent           start high while busy low
// result    done, power                           done high for one cycle
// config    cfg_we, cfg_wdata                     cfg_we high at a clock edge
//
// each modular product is one pass of the 32 multiplier bits through the shared
// multiply-reduce unit, between a launch and a completion; base reduction
// is one such pass. with k exponent bits and w of them set, an item makes
// one base reduction pass and k - 1 + w further passes.
// zero or negative exponent, or modulus below two, answers without the reducer.
// reset is asynchronous, active low; modulus returns to 7681.
// the receiver cannot stall: power is valid only in the done cycle.
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation_core import modexp_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [MOD_W-1:0]         cfg_wdata,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic signed [WORD_W-1:0] base,
	input  wire logic signed [WORD_W-1:0] exponent,
	output logic                          done,
	output logic [MOD_W-1:0]              power
);

	modexp_state_t     state_q;
	logic              done_q;
	logic [MOD_W-1:0]  modulus_q;
	logic [MOD_W-1:0]  acc_q;
	logic [MOD_W-1:0]  b_q;
	logic [MOD_W-1:0]  e_q;
	logic              neg_q;
	logic [MOD_W-1:0]  power_q;

	logic              accept;
	logic              mod_small;
	logic              special;
	logic [WORD_W-1:0] base_mag;
	logic [MOD_W-1:0]  b_fixed;
	mm_req_t           mm_req;
	mm_rsp_t           mm_rsp;

	// command decode
	always_comb begin
		accept    = start && (state_q == ST_IDLE);
		mod_small = (modulus_q < MOD_MIN);
		special   = mod_small || exponent[WORD_W-1] || (exponent == '0);
		base_mag  = base[WORD_W-1] ? (~base + WORD_W'(1)) : base;
		b_fixed   = (neg_q && (mm_rsp.prod != '0)) ? (modulus_q - mm_rsp.prod)
			: mm_rsp.prod;
	end

	// launch the shared unit: base reduction on accept, then acc*b or b*b
	always_comb begin
		mm_req.start  = (accept && !special) || ((state_q == ST_LOOP) && (e_q != '0));
		mm_req.mcand  = ONE_VAL;
		mm_req.mplier = base_mag;
		if (state_q == ST_LOOP) begin
			mm_req.mcand  = e_q[0] ? acc_q : b_q;
			mm_req.mplier = {1'b0, b_q};
		end
	end

	modexp_mulred u_mulred (
		.clk     (clk),
		.arst_n  (arst_n),
		.modulus (modulus_q),
		.req     (mm_req),
		.rsp     (mm_rsp)
	);

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_RESET;
		end else if (cfg_we) begin
			modulus_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (special) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_NORM;
						end
					end
				end
				ST_NORM: begin
					if (mm_rsp.done) begin
						state_q <= ST_LOOP;
					end
				end
				ST_LOOP: begin
					if (e_q == '0) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else if (e_q[0]) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_SQR;
					end
				end
				ST_MUL, ST_SQR: begin
					if (mm_rsp.done) begin
						state_q <= ST_LOOP;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					e_q     <= exponent[MOD_W-1:0];
					neg_q   <= base[WORD_W-1];
					acc_q   <= ONE_VAL;
					power_q <= mod_small ? '0 : ONE_VAL;
				end
			end
			ST_NORM: begin
				if (mm_rsp.done) begin
					b_q <= b_fixed;
				end
			end
			ST_LOOP: begin
				if (e_q == '0) begin
					power_q <= acc_q;
				end
			end
			ST_MUL: begin
				if (mm_rsp.done) begin
					acc_q  <= mm_rsp.prod;
					e_q[0] <= 1'b0;
				end
			end
			ST_SQR: begin
				if (mm_rsp.done) begin
					b_q <= mm_rsp.prod;
					e_q <= {1'b0, e_q[MOD_W-1:1]};
				end
			end
			default: begin
			end
		endcase
	end

	assign busy  = (state_q != ST_IDLE);
	assign done  = done_q;
	assign power = power_q;

	// operands handed to the reducer are already reduced
	a_operands_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOP) |-> ((acc_q < modulus_q) && (b_q < modulus_q)))
		else $error("loop operands not below modulus");

	// a result strobe never overlaps an item still in work
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe while busy");

	// the reducer only completes while the sequencer waits on it
	a_rsp_expected: assert property (@(posedge clk) disable iff (!arst_n)
		mm_rsp.done |-> ((state_q == ST_NORM) || (state_q == ST_MUL) || (state_q == ST_SQR)))
		else $error("reducer completion while not waiting");

endmodule

`default_nettype wire

### verif/tb_top.sv
// testbench for the modular exponentiation core: queued commands, power prediction, checks
`timescale 1ns / 1ps

module tb_top;
	import modexp_pkg::*;

	// kinds of pending work for the command driver
	typedef enum logic [1:0] {
		REQ_POWER,
		REQ_SET_MOD,
		REQ_DRAIN
	} req_kind_t;

	typedef struct {
		req_kind_t                kind;
		logic signed [WORD_W-1:0] base;
		logic signed [WORD_W-1:0] exponent;
		logic [MOD_W-1:0]         modulus;
	} pow_req_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [MOD_W-1:0]         cfg_wdata = MOD_RESET;
	logic                     start = 1'b0;
	logic                     busy;
	logic signed [WORD_W-1:0] base = '0;
	logic signed [WORD_W-1:0] exponent = '0;
	logic                     done;
	logic [MOD_W-1:0]         power;

	pow_req_t         cmd_q[$];
	logic [MOD_W-1:0] power_q[$];
	logic [MOD_W-1:0] cur_mod = MOD_RESET;
	pow_req_t         head;
	logic             nxt_start;
	logic             nxt_we;
	int               gap_left = 0;
	int               accepted_cnt = 0;
	int               checked_cnt = 0;
	int               mod_writes = 0;
	int               err_cnt = 0;

	modular_exponentiation_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.busy      (busy),
		.base      (base),
		.exponent  (exponent),
		.done      (done),
		.power     (power)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// least non-negative residue of a signed word
	function automatic longint unsigned base_residue(logic signed [WORD_W-1:0] b,
			logic [MOD_W-1:0] m);
		longint v;
		longint mm;
		longint r;
		v = b;
		mm = m;
		r = v % mm;
		if (r < 0) begin
			r = r + mm;
		end
		return longint'(r);
	endfunction

	// base^exponent mod m, right-to-left square-and-multiply
	function automatic logic [MOD_W-1:0] expected_power(logic signed [WORD_W-1:0] b,
			logic signed [WORD_W-1:0] e, logic [MOD_W-1:0] m);
		longint unsigned mm;
		longint unsigned acc;
		longint unsigned sq;
		logic [WORD_W-1:0] bits;
		if (m == '0) begin
			return '0;
		end
		mm = m;
		acc = 64'd1 % mm;
		if (e <= 0) begin
			return acc[MOD_W-1:0];
		end
		sq = base_residue(b, m);
		bits = e;
		while (bits != '0) begin
			if (bits[0]) begin
				acc = (acc * sq) % mm;
			end
			sq = (sq * sq) % mm;
			bits = bits >> 1;
		end
		return acc[MOD_W-1:0];
	endfunction

	task automatic push_power(logic signed [WORD_W-1:0] b, logic signed [WORD_W-1:0] e);
		pow_req_t r;
		r.kind = REQ_POWER;
		r.base = b;
		r.exponent = e;
		r.modulus = '0;
		cmd_q.push_back(r);
	endtask

	task automatic push_modulus(logic [MOD_W-1:0] m);
		pow_req_t r;
		r.kind = REQ_SET_MOD;
		r.base = '0;
		r.exponent = '0;
		r.modulus = m;
		cmd_q.push_back(r);
	endtask

	task automatic push_drain();
		pow_req_t r;
		r.kind = REQ_DRAIN;
		r.base = '0;
		r.exponent = '0;
		r.modulus = '0;
		cmd_q.push_back(r);
	endtask

	// random command: mostly short and medium exponents, some full width, zero or negative, and inverses
	task automatic push_random(logic [MOD_W-1:0] m);
		int sel;
		logic signed [WORD_W-1:0] b;
		logic signed [WORD_W-1:0] e;
		sel = $urandom_range(0, 99);
		if (sel < 12) begin
			e = ($urandom_range(0, 3) == 0) ? '0 : {1'b1, 31'($urandom())};
		end else if (sel < 20 && m >= 3) begin
			e = WORD_W'(m) - 2;
		end else if (sel < 55) begin
			e = $urandom_range(1, 255);
		end else if (sel < 80) begin
			e = $urandom_range(1, 65535);
		end else begin
			e = {1'b0, 31'($urandom())};
		end
		sel = $urandom_range(0, 99);
		if (sel < 60) begin
			b = $urandom();
		end else if (sel < 75) begin
			b = $signed($urandom_range(0, 40)) - 20;
		end else if (sel < 85) begin
			b = WORD_W'(m) * $urandom_range(0, 3);
			if ($urandom_range(0, 1) == 1) begin
				b = -b;
			end
		end else begin
			case ($urandom_range(0, 3))
			0: b = 32'sh8000_0000;
			1: b = 32'sh7FFF_FFFF;
			2: b = -32'sd1;
			default: b = '0;
			endcase
		end
		push_power(b, e);
	endtask

	// command driver: issues queued work, tracks accepted transfers and predicts power
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cfg_we <= 1'b0;
			cfg_wdata <= MOD_RESET;
			base <= '0;
			exponent <= '0;
			cur_mod = MOD_RESET;
			gap_left = 0;
		end else begin
			// register write lands at the edge that ends its pulse
			if (cfg_we) begin
				cur_mod = cfg_wdata;
				mod_writes++;
			end
			nxt_start = start;
			nxt_we = 1'b0;
			if (start && !busy) begin
				power_q.push_back(expected_power(base, exponent, cur_mod));
				accepted_cnt++;
				nxt_start = 1'b0;
			end
			// next piece of work once the port is free
			if (!nxt_start && !cfg_we) begin
				if (gap_left != 0) begin
					if (!busy) begin
						gap_left--;
					end
				end else if (cmd_q.size() != 0) begin
					head = cmd_q[0];
					case (head.kind)
					REQ_POWER: begin
						base <= head.base;
						exponent <= head.exponent;
						nxt_start = 1'b1;
						void'(cmd_q.pop_front());
						if (cmd_q.size() > 40 && $urandom_range(0, 2) == 0) begin
							gap_left = $urandom_range(1, 5);
						end
					end
					REQ_SET_MOD: begin
						if (!start && !busy && !done && power_q.size() == 0) begin
							cfg_wdata <= head.modulus;
							nxt_we = 1'b1;
							void'(cmd_q.pop_front());
						end
					end
					default: begin
						if (!start && !busy && !done && power_q.size() == 0) begin
							void'(cmd_q.pop_front());
						end
					end
					endcase
				end
			end
			start <= nxt_start;
			cfg_we <= nxt_we;
		end
	end

	// result monitor: each done transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (power_q.size() == 0) begin
				$display("%0t: result transfer with none expected: expected none, actual %0d",
					$time, power);
				err_cnt++;
			end else begin
				if (power !== power_q[0]) begin
					$display("%0t: power mismatch: expected %0d, actual %0d",
						$time, power_q[0], power);
					err_cnt++;
				end
				void'(power_q.pop_front());
				checked_cnt++;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		logic [MOD_W-1:0] phase_mod[10];
		int n_items;

		// directed: reset modulus 7681
		push_power(32'sd5, 32'sd0);
		push_power(32'sd5, -32'sd1);
		push_power(32'sd5, 32'sh8000_0000);
		push_power(-32'sd1, 32'sd1);
		push_power(32'sh8000_0000, 32'sd1);
		push_power(32'sh7FFF_FFFF, 32'sd1);
		push_power(32'sd0, 32'sd5);
		push_power(32'sd7681, 32'sd3);
		push_power(-32'sd7681, 32'sd3);
		push_power(32'sd3, 32'sd7679);
		push_power(32'sd2, 32'sh7FFF_FFFF);
		push_power(-32'sd2, 32'sh7FFF_FFFE);
		// degenerate moduli
		push_modulus(MOD_W'(1));
		push_power(32'sd5, 32'sd3);
		push_power(-32'sd7, 32'sd0);
		push_modulus(MOD_W'(0));
		push_power(32'sd5, 32'sd3);
		push_power(32'sd9, 32'sd0);
		push_modulus(MOD_MIN);
		push_power(-32'sd3, 32'sd1);
		push_power(32'sd4, 32'sd5);
		// largest modulus, widest products
		push_modulus(MOD_W'(31'h7FFF_FFFF));
		push_power(32'sh7FFF_FFFE, 32'sd2);
		push_power(-32'sd1, 32'sh7FFF_FFFF);
		push_power(32'sh7FFF_FFFF, 32'sd5);
		push_power(32'sd123456789, 32'sh7FFF_FFFD);
		push_drain();

		// random phases, one modulus each
		phase_mod[0] = MOD_W'(12289);
		phase_mod[1] = MOD_W'(3);
		phase_mod[2] = MOD_W'(31'h7FFF_FFFF);
		phase_mod[3] = MOD_W'(998244353);
		phase_mod[4] = MOD_W'($urandom()) | MOD_W'(31'h4000_0001);
		phase_mod[5] = MOD_W'(65537);
		phase_mod[6] = MOD_W'($urandom_range(2, 1000));
		phase_mod[7] = MOD_W'(1);
		phase_mod[8] = MOD_W'(0);
		phase_mod[9] = MOD_RESET;
		for (int p = 0; p < 10; p++) begin
			push_modulus(phase_mod[p]);
			n_items = (phase_mod[p] < 2) ? 8 : 32;
			for (int i = 0; i < n_items; i++) begin
				if (p == 3 && i == 16) begin
					push_drain();
				end
				push_random(phase_mod[p]);
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (cmd_q.size() == 0);
		while (start || busy || done || power_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);

		$display("covered %0d exponentiations (%0d checked) over %0d register writes,",
			accepted_cnt, checked_cnt, mod_writes);
		$display("moduli 0, 1, 2, 3, 2^31-1 and others, signed extremes and inverses");
		if (err_cnt == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// run limit
	initial begin
		#50_000_000;
		$display("timeout with %0d results outstanding", power_q.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
